// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on aclk and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mobm_pkg.sv =====
package mobm_pkg;

    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CHR_W   = 9;
    localparam int PRG_W   = 8;
    localparam int CNT_W   = 9;
    localparam int NUM_CHR = 8;
    localparam int NUM_PRG = 4;
    localparam int NUM_BANK_REGS = 8;
    localparam int NUM_OUTER     = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = NUM_CHR * CHR_W + NUM_PRG * PRG_W;

    localparam logic [CNT_W-1:0] PRG_COUNT_RESET = 9'd64;

    // decode key: {address[15:13], address[0]} (address & 0xE001)
    localparam logic [3:0] DEC_CMD        = 4'b100_0;  // $8000
    localparam logic [3:0] DEC_BANK       = 4'b100_1;  // $8001
    localparam logic [3:0] DEC_OUTER_CTL  = 4'b101_1;  // $A001
    localparam logic [3:0] DEC_OUTER_DATA = 4'b011_0;  // even $6000-$7FFF

    localparam int CMD_CHR_INV_BIT  = 7;
    localparam int CMD_PRG_SWAP_BIT = 6;
    localparam int OUTER_EN_BIT     = 7;

    typedef logic [NUM_BANK_REGS-1:0][BYTE_W-1:0] bank_arr_t;
    typedef logic [NUM_OUTER-1:0][BYTE_W-1:0]     outer_arr_t;

    typedef struct packed {
        logic [NUM_PRG-1:0][PRG_W-1:0] prg;
        logic [NUM_CHR-1:0][CHR_W-1:0] chr;
    } map_t;

    function automatic logic [3:0] decode_addr(input logic [ADDR_W-1:0] addr);
        return {addr[15:13], addr[0]};
    endfunction

    function automatic map_t apply_map(input bank_arr_t banks, input logic [BYTE_W-1:0] cmd,
                                       input outer_arr_t outer);
        logic [BYTE_W-1:0]      cm;
        logic [5:0][BYTE_W-1:0] c;
        logic [BYTE_W-1:0]      pm;
        logic [BYTE_W-1:0]      p0;
        logic [BYTE_W-1:0]      p1;
        logic [BYTE_W-1:0]      pf;
        map_t                   m;
        cm = {outer[2][3:0], 4'hF};
        for (int i = 0; i < 6; i++) begin
            c[i] = (banks[i] | {outer[1][3:0], 4'h0}) & cm;
        end
        if (cmd[CMD_CHR_INV_BIT]) begin
            m.chr[0] = {1'b0, c[2]};
            m.chr[1] = {1'b0, c[3]};
            m.chr[2] = {1'b0, c[4]};
            m.chr[3] = {1'b0, c[5]};
            m.chr[4] = {1'b0, c[0]};
            m.chr[5] = {1'b0, c[0]} + 9'd1;
            m.chr[6] = {1'b0, c[1]};
            m.chr[7] = {1'b0, c[1]} + 9'd1;
        end else begin
            m.chr[0] = {1'b0, c[0]};
            m.chr[1] = {1'b0, c[0]} + 9'd1;
            m.chr[2] = {1'b0, c[1]};
            m.chr[3] = {1'b0, c[1]} + 9'd1;
            m.chr[4] = {1'b0, c[2]};
            m.chr[5] = {1'b0, c[3]};
            m.chr[6] = {1'b0, c[4]};
            m.chr[7] = {1'b0, c[5]};
        end
        pm = {2'b00, ~outer[3][5:0]};
        p0 = (banks[6] & pm) | outer[1];
        p1 = (banks[7] & pm) | outer[1];
        pf = pm | outer[1];
        if (cmd[CMD_PRG_SWAP_BIT]) begin
            m.prg[0] = pf;
            m.prg[1] = p1;
            m.prg[2] = p0;
            m.prg[3] = pf;
        end else begin
            m.prg[0] = p0;
            m.prg[1] = p1;
            m.prg[2] = pf;
            m.prg[3] = pf;
        end
        return m;
    endfunction

    // power-on map: PRG 0, 1, count-2, count-1 (mod 256), CHR all zero
    function automatic map_t default_map(input logic [CNT_W-1:0] cnt);
        map_t m;
        m.chr = '0;
        m.prg[0] = 8'd0;
        m.prg[1] = 8'd1;
        m.prg[2] = cnt[PRG_W-1:0] - 8'd2;
        m.prg[3] = cnt[PRG_W-1:0] - 8'd1;
        return m;
    endfunction

endpackage

// ===== rtl/mmc3_outer_bank_mapper_top.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: address[15:0], value[23:16]
// m_*       out  m_tvalid/m_tready  m_tdata: chr_slot0..7 (9b each), prg_slot0..3 (8b each)
// cfg_*     in   cfg_we             cfg_wdata: prg_bank_count
//
// One item per cycle sustained while m_tready stays high; an accepted item passes through
// the input register, then the mapper update into the result register, before m_tdata.
// aresetn is synchronous, active low; it restores the power-on mapper state.
// A stalled m side holds the result; the input register still takes one more item.
`include "assert_macros.svh"

module mmc3_outer_bank_mapper_top import mobm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // address[15:0], value[23:16]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // chr_slot0[8:0] .. chr_slot7[71:63],
                                              // prg_slot0[79:72] .. prg_slot3[103:96]
    input  logic                   cfg_we,
    input  logic [CNT_W-1:0]       cfg_wdata  // prg_bank_count
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [ADDR_W-1:0]    in_addr_reg;
    logic [BYTE_W-1:0]    in_value_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    map_t                 out_map_reg;
    map_t                 out_map_next;
    logic                 advance;

    logic [CNT_W-1:0]     prg_bank_count_reg;
    bank_arr_t            bank_regs_reg;
    bank_arr_t            bank_regs_next;
    logic [BYTE_W-1:0]    cmd_reg;
    logic [BYTE_W-1:0]    cmd_next;
    logic                 outer_en_reg;
    logic                 outer_en_next;
    logic [1:0]           outer_idx_reg;
    logic [1:0]           outer_idx_next;
    outer_arr_t           outer_bytes_reg;
    outer_arr_t           outer_bytes_next;
    logic                 map_applied_reg;
    logic                 map_applied_next;
    map_t                 applied_reg;
    map_t                 applied_next;
    logic                 do_apply;
    logic [3:0]           dec;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_map_reg;
    assign dec      = decode_addr(in_addr_reg);

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_comb begin
        bank_regs_next   = bank_regs_reg;
        cmd_next         = cmd_reg;
        outer_en_next    = outer_en_reg;
        outer_idx_next   = outer_idx_reg;
        outer_bytes_next = outer_bytes_reg;
        do_apply         = 1'b0;
        if (advance) begin
            case (dec)
                DEC_CMD: begin
                    cmd_next = in_value_reg;
                    do_apply = 1'b1;
                end
                DEC_BANK: begin
                    bank_regs_next[cmd_reg[2:0]] = in_value_reg;
                    do_apply = 1'b1;
                end
                DEC_OUTER_CTL: begin
                    if (in_value_reg[OUTER_EN_BIT]) begin
                        outer_en_next  = 1'b1;
                        outer_idx_next = 2'd0;
                    end else begin
                        outer_en_next = 1'b0;
                    end
                end
                DEC_OUTER_DATA: begin
                    if (outer_en_reg) begin
                        outer_bytes_next[outer_idx_reg] = in_value_reg;
                        outer_idx_next = outer_idx_reg + 2'd1;
                        // fourth byte closes the set
                        do_apply = (outer_idx_reg == 2'd3);
                    end
                end
                default: begin
                end
            endcase
        end
        applied_next     = do_apply ? apply_map(bank_regs_next, cmd_next, outer_bytes_next)
                                    : applied_reg;
        map_applied_next = map_applied_reg || do_apply;
        out_map_next     = map_applied_next ? applied_next : default_map(prg_bank_count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            prg_bank_count_reg <= PRG_COUNT_RESET;
            bank_regs_reg      <= '0;
            cmd_reg            <= '0;
            outer_en_reg       <= 1'b0;
            outer_idx_reg      <= 2'd0;
            outer_bytes_reg    <= '0;
            map_applied_reg    <= 1'b0;
            applied_reg        <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            bank_regs_reg   <= bank_regs_next;
            cmd_reg         <= cmd_next;
            outer_en_reg    <= outer_en_next;
            outer_idx_reg   <= outer_idx_next;
            outer_bytes_reg <= outer_bytes_next;
            map_applied_reg <= map_applied_next;
            applied_reg     <= applied_next;
            if (cfg_we) begin
                prg_bank_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_addr_reg  <= s_tdata[ADDR_W-1:0];
            in_value_reg <= s_tdata[ADDR_W +: BYTE_W];
        end
        if (advance) begin
            out_map_reg <= out_map_next;
        end
    end

    `ASSERT_IMP(a_stall_only_when_full, !s_tready, in_valid_reg && out_valid_reg && !m_tready)
    `ASSERT_IMP(a_unapplied_map_clear, !map_applied_reg, applied_reg == '0)
    `ASSERT_NXT(a_cmd_applies, advance && dec == DEC_CMD, map_applied_reg && m_tvalid)
    `ASSERT_NXT(a_outer_wrap_applies,
        advance && dec == DEC_OUTER_DATA && outer_en_reg && outer_idx_reg == 2'd3,
        map_applied_reg && outer_idx_reg == 2'd0)

endmodule

// ===== sim/mobm_map_checker.sv =====
`timescale 1ns / 1ps

module mobm_map_checker import mobm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // address[15:0], value[23:16]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // chr_slot0..7 (9b each), prg_slot0..3 (8b each)
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata, // prg_bank_count
    output int                    fail_count,
    output int                    pending
);

    // shadow of the mapper registers
    logic [BYTE_W-1:0] bank_bytes [NUM_BANK_REGS];
    logic [BYTE_W-1:0] cmd_q;
    logic              outer_armed;
    logic [1:0]        outer_ptr;
    logic [BYTE_W-1:0] outer_window [NUM_OUTER];
    logic              map_valid;
    map_t              cur_map;
    logic [CNT_W-1:0]  prg_banks_total;

    map_t pending_maps [$];
    int   results_seen;

    function automatic map_t compose_bank_map();
        logic [BYTE_W-1:0] chr_keep;
        logic [BYTE_W-1:0] prg_keep;
        logic [BYTE_W-1:0] fixed_bank;
        logic [BYTE_W-1:0] sel [6];
        logic [CHR_W-1:0]  pairs [4];
        logic [CHR_W-1:0]  singles [4];
        logic [BYTE_W-1:0] r6;
        logic [BYTE_W-1:0] r7;
        logic              chr_inv;
        logic              prg_swap;
        map_t              m;
        chr_keep = {outer_window[2][3:0], 4'hF};
        for (int i = 0; i < 6; i++) begin
            sel[i] = (bank_bytes[i] | (outer_window[1] << 4)) & chr_keep;
        end
        // 2 KB regions get the bank and the one after it (may carry into bit 8)
        pairs[0] = {1'b0, sel[0]};
        pairs[1] = pairs[0] + 9'd1;
        pairs[2] = {1'b0, sel[1]};
        pairs[3] = pairs[2] + 9'd1;
        for (int k = 0; k < 4; k++) begin
            singles[k] = {1'b0, sel[k + 2]};
        end
        chr_inv  = cmd_q[CMD_CHR_INV_BIT];
        prg_swap = cmd_q[CMD_PRG_SWAP_BIT];
        for (int k = 0; k < 4; k++) begin
            m.chr[k]     = chr_inv ? singles[k] : pairs[k];
            m.chr[k + 4] = chr_inv ? pairs[k] : singles[k];
        end
        prg_keep   = ~outer_window[3] & 8'h3F;
        fixed_bank = prg_keep | outer_window[1];
        r6 = (bank_bytes[6] & prg_keep) | outer_window[1];
        r7 = (bank_bytes[7] & prg_keep) | outer_window[1];
        m.prg[0] = prg_swap ? fixed_bank : r6;
        m.prg[1] = r7;
        m.prg[2] = prg_swap ? r6 : fixed_bank;
        m.prg[3] = fixed_bank;
        return m;
    endfunction

    function automatic void latch_map();
        cur_map   = compose_bank_map();
        map_valid = 1'b1;
    endfunction

    function automatic map_t next_bank_map(input logic [ADDR_W-1:0] addr,
                                           input logic [BYTE_W-1:0] val);
        map_t m;
        case ({addr[15:13], addr[0]})
            DEC_CMD: begin
                cmd_q = val;
                latch_map();
            end
            DEC_BANK: begin
                bank_bytes[cmd_q[2:0]] = val;
                latch_map();
            end
            DEC_OUTER_CTL: begin
                outer_armed = val[OUTER_EN_BIT];
                if (val[OUTER_EN_BIT]) begin
                    outer_ptr = 2'd0;
                end
            end
            DEC_OUTER_DATA: begin
                if (outer_armed) begin
                    outer_window[outer_ptr] = val;
                    outer_ptr = outer_ptr + 2'd1;
                    if (outer_ptr == 2'd0) begin
                        latch_map();
                    end
                end
            end
            default: ;
        endcase
        if (map_valid) begin
            m = cur_map;
        end else begin
            m.chr    = '0;
            m.prg[0] = 8'd0;
            m.prg[1] = 8'd1;
            m.prg[2] = prg_banks_total[PRG_W-1:0] - 8'd2;
            m.prg[3] = prg_banks_total[PRG_W-1:0] - 8'd1;
        end
        return m;
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < 10) begin
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        end
        fail_count++;
    endfunction

    function automatic void check_result(input map_t got);
        map_t want;
        if (pending_maps.size() == 0) begin
            note_failure("item on m side with nothing expected");
            return;
        end
        want = pending_maps.pop_front();
        for (int k = 0; k < NUM_CHR; k++) begin
            if (got.chr[k] !== want.chr[k]) begin
                note_failure($sformatf("chr_slot%0d expected %0d, got %0d",
                                       k, want.chr[k], got.chr[k]));
            end
        end
        for (int k = 0; k < NUM_PRG; k++) begin
            if (got.prg[k] !== want.prg[k]) begin
                note_failure($sformatf("prg_slot%0d expected %0d, got %0d",
                                       k, want.prg[k], got.prg[k]));
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BANK_REGS; i++) begin
                bank_bytes[i] = '0;
            end
            for (int i = 0; i < NUM_OUTER; i++) begin
                outer_window[i] = '0;
            end
            cmd_q           = '0;
            outer_armed     = 1'b0;
            outer_ptr       = 2'd0;
            map_valid       = 1'b0;
            cur_map         = '0;
            prg_banks_total = PRG_COUNT_RESET;
            pending_maps.delete();
            results_seen    = 0;
            fail_count      = 0;
            pending         = 0;
        end else begin
            if (cfg_we) begin
                prg_banks_total = cfg_wdata;
            end
            // drain first so a result never matches the item taken at the same edge
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                pending_maps.push_back(next_bank_map(s_tdata[15:0], s_tdata[23:16]));
            end
            pending = pending_maps.size();
        end
    end

endmodule

// ===== sim/mmc3_outer_bank_mapper_top_test.sv =====
`timescale 1ns / 1ps

module mmc3_outer_bank_mapper_top_test;
    import mobm_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CNT_W-1:0]      cfg_wdata;

    int fail_count;
    int pending;

    bit tx_gaps_on;
    bit rx_gaps_on;
    bit rx_hold_req;
    bit outer_on_tx;
    int writes_counted;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mmc3_outer_bank_mapper_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mobm_map_checker map_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // random address that decodes to the given key
    function automatic logic [ADDR_W-1:0] addr_for(input logic [3:0] key);
        logic [11:0] mid;
        mid = 12'($urandom);
        return {key[3:1], mid, key[0]};
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic cpu_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] val);
        int         gap;
        logic [3:0] key;
        gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        key = {addr[15:13], addr[0]};
        if (key == DEC_CMD || key == DEC_BANK || key == DEC_OUTER_CTL ||
            (key == DEC_OUTER_DATA && outer_on_tx)) begin
            writes_counted++;
        end
        if (key == DEC_OUTER_CTL) begin
            outer_on_tx = val[OUTER_EN_BIT];
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_prg_count(input logic [CNT_W-1:0] cnt);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic outer_load(input int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                cpu_write(16'($urandom), rand_byte());
            end
            cpu_write(addr_for(DEC_OUTER_DATA), rand_byte());
        end
    endtask

    task automatic random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            cpu_write(addr_for(DEC_CMD), rand_byte());
            cpu_write(addr_for(DEC_BANK), rand_byte());
        end else if (pick < 55) begin
            cpu_write(addr_for(DEC_OUTER_CTL), 8'h80 | rand_byte());
            outer_load(4);
        end else if (pick < 65) begin
            cpu_write(addr_for(DEC_BANK), rand_byte());
        end else if (pick < 75) begin
            // broken outer sequence: partial fill, or writes while disabled
            cpu_write(addr_for(DEC_OUTER_CTL), rand_byte());
            outer_load($urandom_range(1, 3));
        end else if (pick < 83) begin
            cpu_write(addr_for(DEC_CMD), rand_byte());
        end else begin
            cpu_write(16'($urandom), rand_byte());
        end
    endtask

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side
    initial begin
        int stall;
        m_tready <= 1'b0;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
            end
            stall = rx_gaps_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        int phase_goal;
        bit hold_sent;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        rx_hold_req    = 1'b0;
        outer_on_tx    = 1'b0;
        writes_counted = 0;
        hold_sent      = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // power-on map under several bank counts, with ignored writes only
        cpu_write(16'h0000, 8'h00);
        cpu_write(16'h5FFF, 8'hFF);
        set_prg_count(9'd2);
        cpu_write(16'h6001, 8'hAA);
        set_prg_count(9'd256);
        cpu_write(addr_for(DEC_OUTER_DATA), 8'h55);
        set_prg_count(9'd1);
        cpu_write(addr_for(DEC_OUTER_CTL), 8'h7F);
        set_prg_count(9'd0);
        cpu_write(16'hFFFE, 8'h00);
        set_prg_count(9'd64);

        // first update comes from a full outer window, all ones
        cpu_write(addr_for(DEC_OUTER_CTL), 8'h80);
        repeat (4) cpu_write(addr_for(DEC_OUTER_DATA), 8'hFF);
        // re-enable restarts the byte index
        cpu_write(addr_for(DEC_OUTER_CTL), 8'hFF);
        repeat (4) cpu_write(addr_for(DEC_OUTER_DATA), 8'h00);
        cpu_write(addr_for(DEC_CMD), 8'h00);
        cpu_write(addr_for(DEC_BANK), 8'hFF);
        cpu_write(addr_for(DEC_CMD), 8'h01);
        cpu_write(addr_for(DEC_BANK), 8'hFF);
        cpu_write(addr_for(DEC_CMD), 8'hC6);
        cpu_write(addr_for(DEC_BANK), 8'hAB);
        cpu_write(addr_for(DEC_CMD), 8'h47);
        cpu_write(addr_for(DEC_BANK), 8'h00);
        cpu_write(addr_for(DEC_CMD), 8'h85);
        cpu_write(addr_for(DEC_BANK), 8'h5A);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       set_prg_count(9'd2);
                1:       set_prg_count(9'd256);
                default: set_prg_count(9'($urandom_range(2, 256)));
            endcase
            tx_gaps_on = (phase != 2);
            rx_gaps_on = (phase != 2) && (phase != 4);
            phase_goal = writes_counted + 165;
            while (writes_counted < phase_goal) begin
                if (phase == 3 && !hold_sent && writes_counted >= phase_goal - 145) begin
                    rx_hold_req = 1'b1;
                    hold_sent   = 1'b1;
                end
                if (phase == 5 && $urandom_range(0, 39) == 0) begin
                    drain_results();
                end
                random_burst();
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
